/* hw/rtl/sb64d_pkg.sv */
// Shared types, constants and the alphabet lookup for the strict base64 decoder.
package sb64d_pkg;

	localparam int CfgWidth   = 24;
	localparam int CountWidth = 25;
	localparam int FifoDepth  = 8;
	localparam int PtrWidth   = $clog2(FifoDepth);
	localparam int MaxPush    = 4;

	localparam logic [7:0]            CharPad      = 8'h3D;
	localparam logic [CountWidth-1:0] CountMax     = {CountWidth{1'b1}};
	localparam logic [CfgWidth-1:0]   MaxCharsRst  = 24'd16777215;
	localparam logic [CfgWidth-1:0]   MaxBytesRst  = 24'd12582912;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_TOO_LARGE = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_MAX_CHARS = 1'b0,
		REG_MAX_BYTES = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] status_code;
		logic       final_item;
		logic       byte_valid;
		logic [7:0] data_byte;
	} out_item_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		r.ok    = 1'b1;
		r.value = 6'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			r.value = 6'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7A]}) begin
			r.value = 6'(c - 8'h61 + 8'd26);
		end else if (c inside {[8'h30:8'h39]}) begin
			r.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r.value = 6'd62;
		end else if (c == 8'h2F) begin
			r.value = 6'd63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/strict_base64_decoder.sv */
// Strict base64 decoder: per-character decode, output word queue, APB limit registers.
// Results of a taken input word enter the output queue and leave it in order.
// Throughput: one input word per cycle while the 8-word output queue has room for four words;
// a quartet adds up to three bytes, end of text a status word; m_tready pops one per cycle.
// Reset (arst_n low): text state and queue clear at once, limits return to their defaults;
// no clearing pass is needed.
module strict_base64_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // end_of_text
	input  logic        s_tuser,   // no_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] data_byte, [9:8] status_code, [15:10] zero
	output logic        m_tlast,   // final_item
	output logic        m_tuser,   // byte_valid
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sb64d_pkg::*;

	logic [CfgWidth-1:0]   max_chars_q;
	logic [CfgWidth-1:0]   max_bytes_q;

	logic [1:0]            qpos_q;
	logic [17:0]           held_q;
	logic                  third_pad_q;
	logic                  invalid_q;
	logic [CountWidth-1:0] chars_q;
	logic [CountWidth-1:0] bytes_q;
	logic                  pad_closed_q;

	out_item_t             fifo_mem [FifoDepth];
	logic [PtrWidth-1:0]   wr_ptr_q;
	logic [PtrWidth-1:0]   rd_ptr_q;
	logic [PtrWidth:0]     fifo_cnt_q;

	logic                  acc;
	logic                  pop;
	logic                  cfg_wr;
	logic [7:0]            c;
	logic                  is_pad;
	sextet_t               sx;
	logic [5:0]            sx_val;
	logic [5:0]            second;
	logic [5:0]            third;
	logic [23:0]           triple;

	logic [1:0]            qpos_d;
	logic [17:0]           held_d;
	logic                  third_pad_d;
	logic                  invalid_d;
	logic [CountWidth-1:0] chars_d;
	logic [CountWidth-1:0] bytes_d;
	logic [CountWidth:0]   bytes_sum;
	logic                  pad_closed_d;
	logic [1:0]            n_bytes;
	logic [2:0]            n_push;
	status_t               status;
	out_item_t             res [MaxPush];

	assign acc    = s_tvalid && s_tready;
	assign pop    = m_tvalid && m_tready;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= MaxCharsRst;
			max_bytes_q <= MaxBytesRst;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_MAX_CHARS: max_chars_q <= pwdata[CfgWidth-1:0];
				REG_MAX_BYTES: max_bytes_q <= pwdata[CfgWidth-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_MAX_CHARS: prdata = {{(32-CfgWidth){1'b0}}, max_chars_q};
			REG_MAX_BYTES: prdata = {{(32-CfgWidth){1'b0}}, max_bytes_q};
			default:       prdata = '0;
		endcase
	end

	// decode one character and build the output words
	always_comb begin
		c            = s_tdata;
		is_pad       = (c == CharPad);
		sx           = sextet_of(c);
		sx_val       = sx.ok ? sx.value : 6'd0;
		second       = held_q[11:6];
		third        = held_q[5:0];
		qpos_d       = qpos_q;
		held_d       = held_q;
		third_pad_d  = third_pad_q;
		invalid_d    = invalid_q;
		chars_d      = chars_q;
		bytes_d      = bytes_q;
		pad_closed_d = pad_closed_q;
		n_bytes      = 2'd0;
		triple       = {held_q, 6'd0};
		bytes_sum    = '0;

		if (!s_tuser) begin
			if (chars_q != CountMax) chars_d = chars_q + 1'b1;
			if (pad_closed_q) invalid_d = 1'b1;
			case (qpos_q)
				2'd0, 2'd1: begin
					if (!sx.ok) invalid_d = 1'b1;
					held_d = {held_q[11:0], sx_val};
					qpos_d = qpos_q + 2'd1;
				end
				2'd2: begin
					if (is_pad) begin
						third_pad_d = 1'b1;
						held_d      = {held_q[11:0], 6'd0};
					end else begin
						if (!sx.ok) invalid_d = 1'b1;
						held_d = {held_q[11:0], sx_val};
					end
					qpos_d = 2'd3;
				end
				default: begin
					if (!is_pad && !sx.ok) invalid_d = 1'b1;
					if (third_pad_q && !is_pad) invalid_d = 1'b1;
					if (third_pad_q && second[3:0] != 4'd0) invalid_d = 1'b1;
					if (is_pad && !third_pad_q && third[1:0] != 2'd0) invalid_d = 1'b1;
					triple = {held_q, is_pad ? 6'd0 : sx_val};
					if (!invalid_d) begin
						n_bytes = third_pad_q ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
					end
					bytes_sum = {1'b0, bytes_q} + (CountWidth+1)'(n_bytes);
					bytes_d   = bytes_sum[CountWidth] ? CountMax : bytes_sum[CountWidth-1:0];
					if (third_pad_q || is_pad) pad_closed_d = 1'b1;
					qpos_d      = 2'd0;
					held_d      = '0;
					third_pad_d = 1'b0;
				end
			endcase
		end

		if (chars_d > {1'b0, max_chars_q} || bytes_d > {1'b0, max_bytes_q}) begin
			status = ST_TOO_LARGE;
		end else if (invalid_d || qpos_d != 2'd0) begin
			status = ST_INVALID;
		end else begin
			status = ST_OK;
		end

		res[0] = '{status_code: 2'd0, final_item: 1'b0, byte_valid: 1'b1,
			data_byte: triple[23:16]};
		res[1] = '{status_code: 2'd0, final_item: 1'b0, byte_valid: 1'b1,
			data_byte: triple[15:8]};
		res[2] = '{status_code: 2'd0, final_item: 1'b0, byte_valid: 1'b1,
			data_byte: triple[7:0]};
		res[3] = '0;
		n_push = {1'b0, n_bytes};
		if (s_tlast) begin
			res[n_bytes] = '{status_code: status, final_item: 1'b1, byte_valid: 1'b0,
				data_byte: 8'd0};
			n_push = {1'b0, n_bytes} + 3'd1;
		end
	end

	// text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qpos_q       <= '0;
			held_q       <= '0;
			third_pad_q  <= 1'b0;
			invalid_q    <= 1'b0;
			chars_q      <= '0;
			bytes_q      <= '0;
			pad_closed_q <= 1'b0;
		end else if (acc) begin
			if (s_tlast) begin
				qpos_q       <= '0;
				held_q       <= '0;
				third_pad_q  <= 1'b0;
				invalid_q    <= 1'b0;
				chars_q      <= '0;
				bytes_q      <= '0;
				pad_closed_q <= 1'b0;
			end else begin
				qpos_q       <= qpos_d;
				held_q       <= held_d;
				third_pad_q  <= third_pad_d;
				invalid_q    <= invalid_d;
				chars_q      <= chars_d;
				bytes_q      <= bytes_d;
				pad_closed_q <= pad_closed_d;
			end
		end
	end

	// output word queue
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int k = 0; k < MaxPush; k++) begin
				if (3'(k) < n_push) fifo_mem[wr_ptr_q + PtrWidth'(k)] <= res[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (acc) wr_ptr_q <= wr_ptr_q + PtrWidth'(n_push);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			fifo_cnt_q <= fifo_cnt_q + (acc ? (PtrWidth+1)'(n_push) : '0)
				- (pop ? (PtrWidth+1)'(1) : '0);
		end
	end

	assign s_tready = (fifo_cnt_q <= (PtrWidth+1)'(FifoDepth - MaxPush));
	assign m_tvalid = (fifo_cnt_q != '0);
	assign m_tdata  = {6'd0, fifo_mem[rd_ptr_q].status_code, fifo_mem[rd_ptr_q].data_byte};
	assign m_tlast  = fifo_mem[rd_ptr_q].final_item;
	assign m_tuser  = fifo_mem[rd_ptr_q].byte_valid;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= (PtrWidth+1)'(FifoDepth))
		else $error("output queue overfilled");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tlast |=> qpos_q == 2'd0 && chars_q == '0 && bytes_q == '0 && !invalid_q)
		else $error("text state not cleared after end of text");

	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tuser && m_tdata[7:0] == 8'd0)
		else $error("status word carries byte data");

endmodule
